// ===== hw/rtl/btc_pkg.sv =====
// Shared types, widths and constants of the barometric compensation pipeline.
`default_nettype none

package btc_pkg;

   localparam int RAW_W      = 24;
   localparam int COEF_W     = 16;
   localparam int DT_W       = RAW_W + 1;
   localparam int PROD_W     = DT_W + COEF_W + 1;
   localparam int WIDE_W     = 42;
   localparam int TEMP_W     = 20;
   localparam int T2_W       = 18;
   localparam int SQ_W       = 2 * (TEMP_W + 1);
   localparam int PRES_W     = 21;
   localparam int SPLIT      = 21;
   localparam int REQ_W      = 48;
   localparam int RSP_W      = 48;
   localparam int REG_IDX_W  = 3;

   localparam int FO_STAGES  = 4;
   localparam int SO_STAGES  = 3;
   localparam int PR_STAGES  = 4;
   localparam int NUM_STAGES = FO_STAGES + SO_STAGES + PR_STAGES;

   localparam logic [REG_IDX_W-1:0] REG_SENS_COEFF      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_COEFF    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SENS_TEMPCO     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMPCO   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REF_TEMP_COEFF  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_SENS_COEFF = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_VARIANT_SELECT  = 3'd7;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN  = {1'b1, {(TEMP_W-1){1'b0}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MAX  = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic signed [PRES_W-1:0] PRES_MIN  = {1'b1, {(PRES_W-1){1'b0}}};
   localparam logic signed [PRES_W-1:0] PRES_MAX  = {1'b0, {(PRES_W-1){1'b1}}};

   typedef struct packed {
      logic [COEF_W-1:0]        sens_coeff;
      logic [COEF_W-1:0]        offset_coeff;
      logic [COEF_W-1:0]        sens_tempco;
      logic [COEF_W-1:0]        offset_tempco;
      logic [COEF_W-1:0]        ref_temp_coeff;
      logic [COEF_W-1:0]        temp_sens_coeff;
      logic signed [COEF_W-1:0] temp_offset;
      logic                     variant_select;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [WIDE_W-1:0] off;
      logic signed [WIDE_W-1:0] sens;
      logic signed [TEMP_W-1:0] temp;
      logic [T2_W-1:0]          t2;
   } first_order_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [WIDE_W-1:0] offp;
      logic signed [WIDE_W-1:0] sensp;
      logic signed [TEMP_W-1:0] temp;
   } second_order_type;

endpackage

`default_nettype wire

// ===== hw/rtl/btc_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the compensation pipeline.
`default_nettype none

module btc_pipe_ctrl
   import btc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [NUM_STAGES-1:0] stage_en
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;
   logic [NUM_STAGES-1:0] upstream;

   always_comb begin
      ready[NUM_STAGES] = out_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign stage_en = ready[NUM_STAGES-1:0];
   assign upstream = {valid_ff[NUM_STAGES-2:0], in_valid};

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? upstream[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];

   assert property (@(posedge clock) disable iff (reset)
      !ready[0] |-> ((&valid_ff) && !out_ready))
      else $error("input blocked while a stage is free");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) == $past($countones(valid_ff))
                + int'($past(in_valid && ready[0]))
                - int'($past(valid_ff[NUM_STAGES-1] && out_ready))))
      else $error("item count in pipeline not conserved");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(valid_ff & ~stage_en) & ~valid_ff) == '0))
      else $error("stalled stage lost its item");

endmodule

`default_nettype wire

// ===== hw/rtl/btc_first_order.sv =====
// Stages of dT, the coefficient products and the first-order terms.
`default_nettype none

module btc_first_order
   import btc_pkg::*;
#(
   parameter int ADC_BITS = 24
)
(
   input  wire logic                 clock,
   input  wire logic [FO_STAGES-1:0] stage_en,
   input  wire cfg_type              cfg,
   input  wire logic [RAW_W-1:0]     raw_pressure,
   input  wire logic [RAW_W-1:0]     raw_temperature,
   output      first_order_type      fo
);

   logic [RAW_W-1:0]           d1_s0_ff, d1_s0_in;
   logic [RAW_W-1:0]           d2_s0_ff, d2_s0_in;
   logic [RAW_W-1:0]           d1_s1_ff;
   logic signed [DT_W-1:0]     dt_s1_ff, dt_s1_in;
   logic [RAW_W-1:0]           d1_s2_ff;
   logic signed [PROD_W-1:0]   pc3_ff, pc3_in;
   logic signed [PROD_W-1:0]   pc4_ff, pc4_in;
   logic signed [PROD_W-1:0]   pc6_ff, pc6_in;
   logic signed [2*DT_W-1:0]   pdt2_ff, pdt2_in;
   first_order_type            fo_ff, fo_in;
   logic signed [PROD_W-1:0]   c3_term, c4_term, c6_term;
   logic signed [WIDE_W-1:0]   c1_term, c2_term;

   assign d1_s0_in = RAW_W'(raw_pressure[ADC_BITS-1:0]);
   assign d2_s0_in = RAW_W'(raw_temperature[ADC_BITS-1:0]);

   assign dt_s1_in = $signed({1'b0, d2_s0_ff}) - $signed({1'b0, cfg.ref_temp_coeff, 8'b0});

   assign pc3_in  = dt_s1_ff * $signed({1'b0, cfg.sens_tempco});
   assign pc4_in  = dt_s1_ff * $signed({1'b0, cfg.offset_tempco});
   assign pc6_in  = dt_s1_ff * $signed({1'b0, cfg.temp_sens_coeff});
   assign pdt2_in = dt_s1_ff * dt_s1_ff;

   always_comb begin
      if (cfg.variant_select) begin
         c2_term = $signed(WIDE_W'({cfg.offset_coeff, 16'b0}));
         c4_term = pc4_ff >>> 7;
         c1_term = $signed(WIDE_W'({cfg.sens_coeff, 15'b0}));
         c3_term = pc3_ff >>> 8;
      end else begin
         c2_term = $signed(WIDE_W'({cfg.offset_coeff, 17'b0}));
         c4_term = pc4_ff >>> 6;
         c1_term = $signed(WIDE_W'({cfg.sens_coeff, 16'b0}));
         c3_term = pc3_ff >>> 7;
      end
      c6_term    = pc6_ff >>> 23;
      fo_in.d1   = d1_s2_ff;
      fo_in.off  = c2_term + WIDE_W'(c4_term);
      fo_in.sens = c1_term + WIDE_W'(c3_term);
      fo_in.temp = $signed(TEMP_W'(c6_term)) + $signed(TEMP_W'(cfg.temp_offset)) + TEMP_BASE;
      fo_in.t2   = pdt2_ff[31 +: T2_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d1_s0_ff <= d1_s0_in;
         d2_s0_ff <= d2_s0_in;
      end
      if (stage_en[1]) begin
         d1_s1_ff <= d1_s0_ff;
         dt_s1_ff <= dt_s1_in;
      end
      if (stage_en[2]) begin
         d1_s2_ff <= d1_s1_ff;
         pc3_ff   <= pc3_in;
         pc4_ff   <= pc4_in;
         pc6_ff   <= pc6_in;
         pdt2_ff  <= pdt2_in;
      end
      if (stage_en[3]) begin
         fo_ff <= fo_in;
      end
   end

   assign fo = fo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/btc_second_order.sv =====
// Stages of the low-temperature corrections and the temperature clamp.
`default_nettype none

module btc_second_order
   import btc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [SO_STAGES-1:0] stage_en,
   input  wire logic                 variant_select,
   input  wire first_order_type      fo,
   output      second_order_type     so
);

   localparam int CW = SQ_W + 6;

   first_order_type            fo_s4_ff;
   logic signed [SQ_W-1:0]     dd_ff, dd_in;
   logic signed [SQ_W-1:0]     ee_ff, ee_in;
   logic                       below_base_ff, below_base_in;
   logic                       below_cold_ff, below_cold_in;
   logic signed [TEMP_W:0]     dev_base, dev_cold;

   logic [RAW_W-1:0]           d1_s5_ff;
   logic signed [WIDE_W-1:0]   off_s5_ff, sens_s5_ff;
   logic signed [WIDE_W-1:0]   off2_ff, off2_in;
   logic signed [WIDE_W-1:0]   sens2_ff, sens2_in;
   logic signed [TEMP_W:0]     temp_corr_ff, temp_corr_in;
   logic signed [CW-1:0]       dd_x, ee_x, off2_x, sens2_x;

   second_order_type           so_ff, so_in;

   assign dev_base      = (TEMP_W+1)'(fo.temp) - (TEMP_W+1)'(TEMP_BASE);
   assign dev_cold      = (TEMP_W+1)'(fo.temp) - (TEMP_W+1)'(TEMP_COLD);
   assign dd_in         = dev_base * dev_base;
   assign ee_in         = dev_cold * dev_cold;
   assign below_base_in = fo.temp < TEMP_BASE;
   assign below_cold_in = fo.temp < TEMP_COLD;

   always_comb begin
      dd_x = CW'(dd_ff);
      ee_x = CW'(ee_ff);
      off2_x  = '0;
      sens2_x = '0;
      if (below_base_ff) begin
         if (variant_select) begin
            off2_x  = (dd_x * 48'sd5) >>> 1;
            sens2_x = (dd_x * 48'sd5) >>> 2;
            if (below_cold_ff) begin
               off2_x  = off2_x + ee_x * 48'sd7;
               sens2_x = sens2_x + ((ee_x * 48'sd11) >>> 1);
            end
         end else begin
            off2_x  = (dd_x * 48'sd61) >>> 4;
            sens2_x = dd_x * 48'sd2;
            if (below_cold_ff) begin
               off2_x  = off2_x + ee_x * 48'sd15;
               sens2_x = sens2_x + ee_x * 48'sd8;
            end
         end
      end
      off2_in  = WIDE_W'(off2_x);
      sens2_in = WIDE_W'(sens2_x);
      if (below_base_ff) begin
         temp_corr_in = (TEMP_W+1)'(fo_s4_ff.temp) - (TEMP_W+1)'($signed({1'b0, fo_s4_ff.t2}));
      end else begin
         temp_corr_in = (TEMP_W+1)'(fo_s4_ff.temp);
      end
   end

   always_comb begin
      so_in.d1    = d1_s5_ff;
      so_in.offp  = off_s5_ff - off2_ff;
      so_in.sensp = sens_s5_ff - sens2_ff;
      if (temp_corr_ff < (TEMP_W+1)'(TEMP_MIN)) begin
         so_in.temp = TEMP_MIN;
      end else if (temp_corr_ff > (TEMP_W+1)'(TEMP_MAX)) begin
         so_in.temp = TEMP_MAX;
      end else begin
         so_in.temp = TEMP_W'(temp_corr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         fo_s4_ff      <= fo;
         dd_ff         <= dd_in;
         ee_ff         <= ee_in;
         below_base_ff <= below_base_in;
         below_cold_ff <= below_cold_in;
      end
      if (stage_en[1]) begin
         d1_s5_ff     <= fo_s4_ff.d1;
         off_s5_ff    <= fo_s4_ff.off;
         sens_s5_ff   <= fo_s4_ff.sens;
         off2_ff      <= off2_in;
         sens2_ff     <= sens2_in;
         temp_corr_ff <= temp_corr_in;
      end
      if (stage_en[2]) begin
         so_ff <= so_in;
      end
   end

   assign so = so_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/btc_pressure.sv =====
// Stages of the split pressure product, the final shifts and the pressure clamp.
`default_nettype none

module btc_pressure
   import btc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [PR_STAGES-1:0]     stage_en,
   input  wire second_order_type         so,
   output      logic signed [TEMP_W-1:0] temperature_centi,
   output      logic signed [PRES_W-1:0] pressure_pascal
);

   localparam int LO_W = RAW_W + SPLIT;
   localparam int HI_W = RAW_W + 1 + WIDE_W - SPLIT;
   localparam int QW   = HI_W + 1;
   localparam int RW   = QW + 1 - 15;

   logic [LO_W-1:0]            pp_lo_ff, pp_lo_in;
   logic signed [HI_W-1:0]     pp_hi_ff, pp_hi_in;
   logic signed [WIDE_W-1:0]   offp_s7_ff, offp_s8_ff;
   logic signed [TEMP_W-1:0]   temp_s7_ff, temp_s8_ff, temp_s9_ff, temp_s10_ff;
   logic signed [QW-1:0]       q_ff, q_in;
   logic signed [QW:0]         diff;
   logic signed [RW-1:0]       r_ff, r_in;
   logic signed [PRES_W-1:0]   pres_ff, pres_in;

   assign pp_lo_in = so.d1 * so.sensp[SPLIT-1:0];
   assign pp_hi_in = $signed({1'b0, so.d1}) * $signed(so.sensp[WIDE_W-1:SPLIT]);

   assign q_in = QW'(pp_hi_ff) + $signed(QW'(pp_lo_ff[LO_W-1:SPLIT]));

   assign diff = (QW+1)'(q_ff) - (QW+1)'(offp_s8_ff);
   assign r_in = RW'(diff >>> 15);

   always_comb begin
      if (r_ff < RW'(PRES_MIN)) begin
         pres_in = PRES_MIN;
      end else if (r_ff > RW'(PRES_MAX)) begin
         pres_in = PRES_MAX;
      end else begin
         pres_in = PRES_W'(r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         offp_s7_ff <= so.offp;
         temp_s7_ff <= so.temp;
      end
      if (stage_en[1]) begin
         q_ff       <= q_in;
         offp_s8_ff <= offp_s7_ff;
         temp_s8_ff <= temp_s7_ff;
      end
      if (stage_en[2]) begin
         r_ff       <= r_in;
         temp_s9_ff <= temp_s8_ff;
      end
      if (stage_en[3]) begin
         pres_ff     <= pres_in;
         temp_s10_ff <= temp_s9_ff;
      end
   end

   assign temperature_centi = temp_s10_ff;
   assign pressure_pascal   = pres_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/baro_temp_compensation.sv =====
// Top level of the barometric temperature and pressure compensation pipeline.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  raw pressure, raw temperature
//   rsp      out        rsp_tvalid/rsp_tready  temperature (0.01 degC), pressure (Pa)
//   csr      in         csr_wen                register index, write data
//
// One item per cycle sustained while rsp_tready is high; 11 register stages.
// The pressure product is split into two partial products, summed in the next stage.
// Synchronous reset clears the valid bits and the calibration registers.
// Each stage holds while the next one is full and stalled; empty stages fill behind a stall.
`default_nettype none

module baro_temp_compensation
   import btc_pkg::*;
#(
   parameter int ADC_BITS = 24
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,   // raw_pressure[23:0], raw_temperature[47:24]

   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [RSP_W-1:0]     rsp_tdata,   // temperature_centi[19:0], pressure_pascal[40:20]

   input  wire logic                 csr_wen,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_wdata
);

   localparam int RSP_PAD = RSP_W - TEMP_W - PRES_W;

   cfg_type                   cfg_ff, cfg_in;
   logic [NUM_STAGES-1:0]     stage_en;
   first_order_type           fo;
   second_order_type          so;
   logic signed [TEMP_W-1:0]  temperature_centi;
   logic signed [PRES_W-1:0]  pressure_pascal;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_SENS_COEFF:      cfg_in.sens_coeff      = csr_wdata;
            REG_OFFSET_COEFF:    cfg_in.offset_coeff    = csr_wdata;
            REG_SENS_TEMPCO:     cfg_in.sens_tempco     = csr_wdata;
            REG_OFFSET_TEMPCO:   cfg_in.offset_tempco   = csr_wdata;
            REG_REF_TEMP_COEFF:  cfg_in.ref_temp_coeff  = csr_wdata;
            REG_TEMP_SENS_COEFF: cfg_in.temp_sens_coeff = csr_wdata;
            REG_TEMP_OFFSET:     cfg_in.temp_offset     = $signed(csr_wdata);
            REG_VARIANT_SELECT:  cfg_in.variant_select  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   btc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (stage_en)
   );

   btc_first_order #(
      .ADC_BITS (ADC_BITS)
   ) u_first (
      .clock           (clock),
      .stage_en        (stage_en[FO_STAGES-1:0]),
      .cfg             (cfg_ff),
      .raw_pressure    (req_tdata[RAW_W-1:0]),
      .raw_temperature (req_tdata[2*RAW_W-1:RAW_W]),
      .fo              (fo)
   );

   btc_second_order u_second (
      .clock          (clock),
      .stage_en       (stage_en[FO_STAGES+SO_STAGES-1:FO_STAGES]),
      .variant_select (cfg_ff.variant_select),
      .fo             (fo),
      .so             (so)
   );

   btc_pressure u_pressure (
      .clock             (clock),
      .stage_en          (stage_en[NUM_STAGES-1:FO_STAGES+SO_STAGES]),
      .so                (so),
      .temperature_centi (temperature_centi),
      .pressure_pascal   (pressure_pascal)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, pressure_pascal, temperature_centi};

endmodule

`default_nettype wire
